>>> hdl/sdspi_pkg.sv
// Shared types, command codes and response tables for the SD SPI responder.
`default_nettype none

package sdspi_pkg;

    // Bytes in one command frame: index byte, four argument bytes, CRC byte
    localparam int CMD_BYTES = 6;
    localparam int CNT_W     = $clog2(CMD_BYTES);
    localparam int POS_W     = 3;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] BYTE_ERROR = 8'h00;
    localparam logic [7:0] INDEX_MASK = 8'b0011_1111;

    // Command indexes
    localparam logic [5:0] CMD_GO_IDLE         = 6'd0;
    localparam logic [5:0] CMD_SEND_STATUS     = 6'd13;
    localparam logic [5:0] CMD_APP_CMD         = 6'd55;
    localparam logic [5:0] CMD_READ_OCR        = 6'd58;
    localparam logic [5:0] ACMD_SEND_OP_COND   = 6'd41;

    localparam logic [POS_W-1:0] LEN_R1 = 3'd1;
    localparam logic [POS_W-1:0] LEN_R2 = 3'd2;
    localparam logic [POS_W-1:0] LEN_R3 = 3'd5;

    typedef enum logic [1:0] {
        PHASE_BOOT = 2'd0,
        PHASE_SPI  = 2'd1,
        PHASE_IDLE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        RESP_R1_IDLE    = 3'd0,
        RESP_R1_OK      = 3'd1,
        RESP_R1_ILLEGAL = 3'd2,
        RESP_R2         = 3'd3,
        RESP_R3         = 3'd4
    } resp_kind_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [7:0]       first_cmd;
        resp_kind_t       kind;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] len;
        phase_t           phase;
        logic             armed;
    } card_state_t;

    // Byte at a position of a queued response
    function automatic logic [7:0] resp_byte(resp_kind_t kind, logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case (kind)
            RESP_R1_IDLE:    b = 8'b0000_0001;
            RESP_R1_OK:      b = 8'h00;
            RESP_R1_ILLEGAL: b = 8'b0000_0100;
            RESP_R2:         b = 8'h00;
            RESP_R3:
            begin
                if (pos == 3'd1)
                    b = 8'b1000_0001;
                else if (pos == 3'd2)
                    b = 8'b1111_1111;
                else
                    b = 8'h00;
            end
            default:         b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sdspi_step.sv
// Next-state and reply logic for one exchanged byte.
`default_nettype none

module sdspi_step (
    input  sdspi_pkg::card_state_t cur,
    input  logic [7:0]             mosi_byte,
    output sdspi_pkg::card_state_t nxt,
    output logic [7:0]             miso_byte
);
    import sdspi_pkg::*;

    logic       pending;
    logic       in_cmd;
    logic [7:0] first;
    logic [5:0] idx;

    always_comb
    begin
        nxt       = cur;
        miso_byte = BYTE_IDLE;
        pending   = cur.pos < cur.len;
        in_cmd    = (mosi_byte != BYTE_IDLE) || (cur.cnt != '0);
        first     = (cur.cnt == '0) ? mosi_byte : cur.first_cmd;
        idx       = 6'(first & INDEX_MASK);

        if (in_cmd && pending)
        begin
            // host broke into a response: clear the byte count, the queued reply and the arm flag, back to boot
            nxt.cnt   = '0;
            nxt.pos   = '0;
            nxt.len   = '0;
            nxt.phase = PHASE_BOOT;
            nxt.armed = 1'b0;
            miso_byte = BYTE_ERROR;
        end
        else if (in_cmd)
        begin
            nxt.first_cmd = first;
            if (cur.cnt == CNT_W'(CMD_BYTES - 1))
            begin
                nxt.cnt = '0;
                nxt.pos = '0;
                if (!cur.armed)
                begin
                    case (idx)
                        CMD_GO_IDLE:
                        begin
                            nxt.phase = PHASE_SPI;
                            nxt.kind  = RESP_R1_IDLE;
                            nxt.len   = LEN_R1;
                        end
                        CMD_SEND_STATUS:
                        begin
                            nxt.kind = RESP_R2;
                            nxt.len  = LEN_R2;
                        end
                        CMD_APP_CMD:
                        begin
                            nxt.armed = 1'b1;
                            nxt.kind  = RESP_R1_OK;
                            nxt.len   = LEN_R1;
                        end
                        CMD_READ_OCR:
                        begin
                            nxt.kind = RESP_R3;
                            nxt.len  = LEN_R3;
                        end
                        default:
                        begin
                            nxt.kind = RESP_R1_ILLEGAL;
                            nxt.len  = LEN_R1;
                        end
                    endcase
                end
                else
                begin
                    // application command: disarm whatever it turns out to be
                    nxt.armed = 1'b0;
                    nxt.len   = LEN_R1;
                    if (idx == ACMD_SEND_OP_COND)
                    begin
                        nxt.kind = RESP_R1_OK;
                        if (cur.phase == PHASE_SPI)
                            nxt.phase = PHASE_IDLE;
                    end
                    else
                    begin
                        nxt.kind = RESP_R1_ILLEGAL;
                    end
                end
            end
            else
            begin
                nxt.cnt = cur.cnt + CNT_W'(1);
            end
        end
        else if (pending)
        begin
            miso_byte = resp_byte(cur.kind, cur.pos);
            nxt.pos   = cur.pos + POS_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> hdl/sd_spi_command_responder.sv
// Top level of the SD SPI mode card-side command responder.
//
//   channel  direction  handshake           payload
//   in       to card    in_valid/in_stall   chip_selected, mosi_byte
//   out      from card  out_valid/out_stall miso_byte
//
// One byte word per cycle while in_stall is low: a word accepted at one edge has
// its reply in the output register after that edge; the card state updates in the same cycle.
// A word with chip_selected low is taken and gives no reply.
// Reset (rst_n low) puts the card in boot phase with nothing queued.
// in_stall rises only while a reply word waits and out_stall holds it.
`default_nettype none

module sd_spi_command_responder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       chip_selected,
    input  logic [7:0] mosi_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] miso_byte
);
    import sdspi_pkg::*;

    card_state_t state_reg;
    card_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  miso_reg;
    logic [7:0]  miso_next;
    logic [7:0]  step_miso;
    logic        in_acc;
    logic        out_hold;

    sdspi_step u_step (
        .cur       (state_reg),
        .mosi_byte (mosi_byte),
        .nxt       (state_next),
        .miso_byte (step_miso)
    );

    assign out_hold = out_valid_reg && out_stall;
    assign in_stall = out_hold;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        miso_next      = miso_reg;
        if (!out_hold)
        begin
            out_valid_next = in_acc && chip_selected;
            miso_next      = step_miso;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            miso_reg      <= BYTE_IDLE;
        end
        else
        begin
            if (in_acc && chip_selected)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            miso_reg      <= miso_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign miso_byte = miso_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pos <= state_reg.len)
        else $error("response position past its length");

    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.len <= LEN_R3)
        else $error("response length out of range");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cnt < CNT_W'(CMD_BYTES))
        else $error("command byte count out of range");

    a_break_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && chip_selected && mosi_byte != BYTE_IDLE &&
        state_reg.pos < state_reg.len
        |=> out_valid_reg && miso_reg == BYTE_ERROR &&
            state_reg.phase == PHASE_BOOT && state_reg.len == '0)
        else $error("break-in during response did not reset the card");

    a_deselect_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !chip_selected |=> !out_valid_reg && $stable(state_reg))
        else $error("deselected word produced a reply or changed state");

endmodule

`default_nettype wire

>>> tb/tb_sd_spi_command_responder.sv
// Self-checking testbench for the SD SPI mode command responder.
`timescale 1ns / 1ps

module tb_sd_spi_command_responder;

    import sdspi_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // Reply bytes that the card queues
    localparam logic [7:0] R1_IN_IDLE = 8'b0000_0001;
    localparam logic [7:0] R1_READY   = 8'h00;
    localparam logic [7:0] R1_ILLEGAL = 8'b0000_0100;
    localparam logic [7:0] OCR_BYTE1  = 8'b1000_0001;
    localparam logic [7:0] OCR_BYTE2  = 8'b1111_1111;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       chip_selected;
    logic [7:0] mosi_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] miso_byte;

    // Card model state
    int         frame_cnt;
    logic [7:0] frame_first;
    logic [7:0] reply_buf [5];
    int         reply_pos;
    int         reply_len;
    phase_t     card_ph;
    logic       app_armed;

    logic [7:0] miso_expect_q [$];
    int         err_count;
    int         cycle_cnt;
    int         sel_words;
    int         desel_words;
    int         frames;
    int         error_resets;
    bit         idle_on;
    int         stall_left = 0;

    sd_spi_command_responder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .chip_selected (chip_selected),
        .mosi_byte     (mosi_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .miso_byte     (miso_byte)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_card();
        frame_cnt = 0;
        reply_pos = 0;
        reply_len = 0;
        card_ph   = PHASE_BOOT;
        app_armed = 1'b0;
    endfunction

    // Work out the miso byte for one accepted word and advance the card state
    function automatic void predict_card_reply(logic cs, logic [7:0] b);
        logic [5:0] idx;
        if (!cs)
        begin
            desel_words++;
            return;
        end
        sel_words++;
        if (b != BYTE_IDLE || frame_cnt != 0)
        begin
            // any command byte while a reply is still queued resets the card
            if (reply_pos < reply_len)
            begin
                clear_card();
                error_resets++;
                miso_expect_q.push_back(BYTE_ERROR);
                return;
            end
            if (frame_cnt == 0)
                frame_first = b;
            frame_cnt++;
        end
        if (frame_cnt >= CMD_BYTES)
        begin
            frame_cnt = 0;
            frames++;
            reply_pos = 0;
            idx = frame_first[5:0];
            if (!app_armed)
            begin
                if (idx == CMD_GO_IDLE)
                begin
                    clear_card();
                    card_ph = PHASE_SPI;
                    reply_buf[0] = R1_IN_IDLE;
                    reply_len = 1;
                end
                else if (idx == CMD_SEND_STATUS)
                begin
                    reply_buf[0] = R1_READY;
                    reply_buf[1] = R1_READY;
                    reply_len = 2;
                end
                else if (idx == CMD_APP_CMD)
                begin
                    app_armed = 1'b1;
                    reply_buf[0] = R1_READY;
                    reply_len = 1;
                end
                else if (idx == CMD_READ_OCR)
                begin
                    reply_buf[0] = R1_READY;
                    reply_buf[1] = OCR_BYTE1;
                    reply_buf[2] = OCR_BYTE2;
                    reply_buf[3] = 8'h00;
                    reply_buf[4] = 8'h00;
                    reply_len = 5;
                end
                else
                begin
                    reply_buf[0] = R1_ILLEGAL;
                    reply_len = 1;
                end
            end
            else
            begin
                app_armed = 1'b0;
                if (idx == ACMD_SEND_OP_COND)
                begin
                    reply_buf[0] = R1_READY;
                    reply_len = 1;
                    if (card_ph == PHASE_SPI)
                        card_ph = PHASE_IDLE;
                end
                else
                begin
                    reply_buf[0] = R1_ILLEGAL;
                    reply_len = 1;
                end
            end
            miso_expect_q.push_back(BYTE_IDLE);
            return;
        end
        if (reply_pos < reply_len)
        begin
            miso_expect_q.push_back(reply_buf[reply_pos]);
            reply_pos++;
        end
        else
            miso_expect_q.push_back(BYTE_IDLE);
    endfunction

    // Drive one word, hold it until accepted, then predict its reply
    task automatic send_word(logic cs, logic [7:0] b);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        chip_selected <= cs;
        mosi_byte     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_card_reply(cs, b);
    endtask

    task automatic send_frame(logic [7:0] first);
        send_word(1'b1, first);
        repeat (CMD_BYTES - 1)
        begin
            if ($urandom_range(0, 31) == 0)
                send_word(1'b0, 8'($urandom_range(0, 255)));
            send_word(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    // Clock out the queued reply with idle bytes, with the odd deselected word between
    task automatic drain_reply();
        while (reply_pos < reply_len)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(1'b0, 8'($urandom_range(0, 255)));
            else
                send_word(1'b1, BYTE_IDLE);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (miso_expect_q.size() != 0);
    endtask

    task automatic test_deselect_and_idle();
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b1, BYTE_IDLE);
        send_word(1'b0, 8'h5A);
        send_word(1'b1, BYTE_IDLE);
    endtask

    task automatic test_each_command();
        send_frame({2'b01, CMD_GO_IDLE});
        drain_reply();
        send_frame({2'b01, CMD_SEND_STATUS});
        drain_reply();
        send_frame({2'b11, CMD_READ_OCR});
        drain_reply();
        send_frame({2'b01, CMD_APP_CMD});
        drain_reply();
        send_frame({2'b01, ACMD_SEND_OP_COND});
        drain_reply();
        // unknown application command disarms too
        send_frame({2'b01, CMD_APP_CMD});
        drain_reply();
        send_frame(8'hBF);
        drain_reply();
        send_frame(8'h02);
        drain_reply();
        send_frame(8'h00);
        drain_reply();
    endtask

    task automatic test_reply_interrupted();
        send_frame({2'b01, CMD_READ_OCR});
        send_word(1'b1, BYTE_IDLE);
        send_word(1'b1, BYTE_IDLE);
        send_word(1'b1, 8'h00);
        send_frame({2'b01, CMD_SEND_STATUS});
        send_word(1'b0, 8'h12);
        send_word(1'b1, 8'h80);
        send_word(1'b1, BYTE_IDLE);
    endtask

    task automatic test_random_traffic(int words, bit idling);
        int         stop_at;
        int         r;
        logic [5:0] idx;
        logic [7:0] first;
        idle_on = idling;
        stop_at = sel_words + words;
        while (sel_words < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                repeat ($urandom_range(0, 2))
                    send_word(1'b1, BYTE_IDLE);
                case ($urandom_range(0, 6))
                    0:       idx = CMD_GO_IDLE;
                    1:       idx = CMD_SEND_STATUS;
                    2, 3:    idx = CMD_APP_CMD;
                    4:       idx = CMD_READ_OCR;
                    5:       idx = ACMD_SEND_OP_COND;
                    default: idx = 6'($urandom_range(0, 63));
                endcase
                first = {2'($urandom_range(0, 3)), idx};
                // an all-ones byte would be skipped as idle
                if (first == BYTE_IDLE)
                    first = 8'h7F;
                send_frame(first);
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(0, 2))
                        send_word(1'b1, BYTE_IDLE);
                    send_word(1'b1, 8'($urandom_range(0, 254)));
                end
                else
                begin
                    drain_reply();
                    if (idx == CMD_APP_CMD && $urandom_range(0, 1) == 1)
                    begin
                        send_frame({2'b01, ACMD_SEND_OP_COND});
                        drain_reply();
                    end
                end
            end
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 8))
                    send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                // partial frame; later words complete or break it
                send_word(1'b1, 8'($urandom_range(0, 254)));
                repeat ($urandom_range(0, 4))
                    send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = int'($urandom_range(1, 19)) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted reply word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (miso_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual miso_byte=%02h",
                         $time, miso_byte);
                err_count++;
            end
            else
            begin
                if (miso_byte !== miso_expect_q[0])
                begin
                    $display("%0t: miso_byte mismatch, expected %02h, actual %02h",
                             $time, miso_expect_q[0], miso_byte);
                    err_count++;
                end
                void'(miso_expect_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words outstanding", $time, miso_expect_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        chip_selected = 1'b0;
        mosi_byte     = 8'h00;
        idle_on       = 1'b1;
        err_count     = 0;
        cycle_cnt     = 0;
        sel_words     = 0;
        desel_words   = 0;
        frames        = 0;
        error_resets  = 0;
        frame_first   = 8'h00;
        foreach (reply_buf[i])
            reply_buf[i] = 8'h00;
        clear_card();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_deselect_and_idle();
        test_each_command();
        test_reply_interrupted();
        wait_drained();
        test_random_traffic(600, 1'b1);
        wait_drained();
        test_random_traffic(380, 1'b1);
        wait_drained();
        test_random_traffic(270, 1'b0);

        in_valid <= 1'b0;
        idle_on = 1'b0;
        while (miso_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d selected and %0d deselected words: %0d command frames decoded,",
                 sel_words, desel_words, frames);
        $display("%0d card resets from words during a queued reply", error_resets);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
